FILE: rtl/pfdr_pkg.sv
`timescale 1ns / 1ps
// pfdr_pkg: shared types, codes and sizes of the packed framebuffer block
// no dependencies
package pfdr_pkg;

    localparam int MEM_BYTES = 8192;
    localparam int MAX_DIM   = 256;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;

    typedef logic [ADDR_W-1:0] t_addr;

    // request codes
    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_GET   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_RSTD  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FORMAT = 2'd2;

    // classified operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_SET   = 3'd1;
    localparam logic [2:0] OP_GET   = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_RSTD  = 3'd4;

    localparam logic [7:0] NIB_LO   = 8'h0F;
    localparam logic [7:0] BIT_MSB  = 8'h80;
    localparam logic [7:0] BYTE_ALL = 8'hFF;

    typedef struct packed {
        logic [2:0] op;
        t_addr      addr;
        logic [2:0] bitsel;
        logic [7:0] data;
        logic [7:0] x;
        logic [7:0] y;
    } t_cmd;

    typedef struct packed {
        logic       gray;
        t_addr      last;
        logic [8:0] w;
        logic [8:0] h;
    } t_frame;

endpackage

FILE: rtl/pfdr_front.sv
`timescale 1ns / 1ps
// pfdr_front: configuration registers, frame geometry and item classification
// depends on pfdr_pkg
module pfdr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_req_type,
    input  logic signed [15:0]   i_pos_x,
    input  logic signed [15:0]   i_pos_y,
    input  logic [7:0]           i_pixel_value,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [8:0]           i_cfg_data,
    input  logic                 i_q_full,
    output logic                 o_push,
    output pfdr_pkg::t_cmd       o_cmd,
    output pfdr_pkg::t_frame     o_frame
);

    logic [8:0]  r_width;
    logic [8:0]  r_height;
    logic        r_gray;
    logic        r_ok;
    logic [7:0]  r_stride;
    logic [8:0]  r_w_eff;
    logic [8:0]  r_h_eff;
    pfdr_pkg::t_addr r_last;

    logic        r_fv;
    logic [1:0]  r_req;
    logic [15:0] r_x;
    logic [15:0] r_y;
    logic [7:0]  r_val;

    logic [9:0]  n_stride;
    logic [17:0] n_prod;
    logic        n_ok;
    logic        accept;
    logic        x_in;
    logic        y_in;
    logic [7:0]  col;
    logic [15:0] lin;
    logic [7:0]  fill;

    // frame geometry
    always_comb begin
        if (r_gray) begin
            n_stride = ({1'b0, r_width} + 10'd1) >> 1;
        end else begin
            n_stride = ({1'b0, r_width} + 10'd7) >> 3;
        end
        n_prod = 18'(n_stride[8:0]) * 18'(r_height);
        n_ok   = (r_width != 9'd0) && (r_height != 9'd0)
              && (r_width <= 9'(pfdr_pkg::MAX_DIM)) && (r_height <= 9'(pfdr_pkg::MAX_DIM))
              && (n_prod <= 18'(pfdr_pkg::MEM_BYTES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
            r_gray   <= 1'b0;
            r_ok     <= 1'b0;
            r_stride <= '0;
            r_w_eff  <= '0;
            r_h_eff  <= '0;
            r_last   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pfdr_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    pfdr_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    pfdr_pkg::CFG_FORMAT: r_gray   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_ok     <= n_ok;
            r_stride <= n_stride[7:0];
            r_w_eff  <= n_ok ? r_width : 9'd0;
            r_h_eff  <= n_ok ? r_height : 9'd0;
            r_last   <= pfdr_pkg::t_addr'(n_prod - 18'd1);
        end
    end

    // input stage
    assign o_push = r_fv && !i_q_full;
    assign busy   = r_fv && i_q_full;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (accept) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req_type;
            r_x   <= i_pos_x;
            r_y   <= i_pos_y;
            r_val <= i_pixel_value;
        end
    end

    // classification
    always_comb begin
        x_in = !r_x[15] && (r_x[14:0] < {6'd0, r_w_eff});
        y_in = !r_y[15] && (r_y[14:0] < {6'd0, r_h_eff});
        col  = r_gray ? {1'b0, r_x[7:1]} : {3'd0, r_x[7:3]};
        lin  = 16'(r_y[7:0]) * 16'(r_stride) + 16'(col);
        if (r_gray) begin
            fill = {r_val[3:0], r_val[3:0]};
        end else begin
            fill = (r_val != 8'd0) ? pfdr_pkg::BYTE_ALL : 8'd0;
        end

        o_cmd.addr   = pfdr_pkg::t_addr'(lin);
        o_cmd.bitsel = r_x[2:0];
        o_cmd.x      = r_x[7:0];
        o_cmd.y      = r_y[7:0];
        o_cmd.data   = r_gray ? (r_val & pfdr_pkg::NIB_LO) : {7'd0, r_val != 8'd0};
        unique case (r_req)
            pfdr_pkg::REQ_SET:   o_cmd.op = (x_in && y_in) ? pfdr_pkg::OP_SET : pfdr_pkg::OP_NONE;
            pfdr_pkg::REQ_GET:   o_cmd.op = (x_in && y_in) ? pfdr_pkg::OP_GET : pfdr_pkg::OP_NONE;
            pfdr_pkg::REQ_CLEAR: begin
                o_cmd.op   = r_ok ? pfdr_pkg::OP_CLEAR : pfdr_pkg::OP_NONE;
                o_cmd.data = fill;
            end
            pfdr_pkg::REQ_RSTD:  o_cmd.op = pfdr_pkg::OP_RSTD;
            default:             o_cmd.op = pfdr_pkg::OP_NONE;
        endcase

        o_frame.gray = r_gray;
        o_frame.last = r_last;
        o_frame.w    = r_w_eff;
        o_frame.h    = r_h_eff;
    end

endmodule

FILE: rtl/pfdr_fifo.sv
`timescale 1ns / 1ps
// pfdr_fifo: short command queue between classification and execution
// depends on pfdr_pkg
module pfdr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pfdr_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output pfdr_pkg::t_cmd o_cmd,
    output logic           o_full,
    output logic           o_empty
);

    pfdr_pkg::t_cmd r_mem [pfdr_pkg::Q_DEPTH];
    logic [pfdr_pkg::Q_PTR_W-1:0] r_wp;
    logic [pfdr_pkg::Q_PTR_W-1:0] r_rp;
    logic [pfdr_pkg::Q_PTR_W:0]   r_cnt;
    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (pfdr_pkg::Q_PTR_W+1)'(pfdr_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

FILE: rtl/pfdr_back.sv
`timescale 1ns / 1ps
// pfdr_back: pixel store, read-modify-write, clear sweep and dirty rectangle
// depends on pfdr_pkg
module pfdr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_clr,
    input  logic             i_q_empty,
    input  pfdr_pkg::t_cmd   i_cmd,
    input  pfdr_pkg::t_frame i_frame,
    output logic             o_pop,
    output logic             o_valid,
    output logic [3:0]       o_read_value,
    output logic             o_is_dirty,
    output logic [7:0]       o_region_x,
    output logic [7:0]       o_region_y,
    output logic [8:0]       o_region_w,
    output logic [8:0]       o_region_h
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RMW  = 2'd1;
    localparam logic [1:0] S_CLR  = 2'd2;
    localparam logic [1:0] S_INIT = 2'd3;

    logic [7:0] mem [pfdr_pkg::MEM_BYTES];

    logic [1:0]      r_state, n_state;
    pfdr_pkg::t_cmd  r_cmd, n_cmd;
    pfdr_pkg::t_addr r_addr, n_addr;
    logic [7:0]      r_rdata;
    logic            r_dirty, n_dirty;
    logic [7:0]      r_left, n_left;
    logic [7:0]      r_top, n_top;
    logic [8:0]      r_dw, n_dw;
    logic [8:0]      r_dh, n_dh;
    logic            r_valid, n_valid;
    logic [3:0]      r_read, n_read;

    logic            mem_we;
    pfdr_pkg::t_addr mem_waddr;
    logic [7:0]      mem_wdata;
    logic [7:0]      mask;
    logic [7:0]      x0, y0;
    logic [8:0]      x1, y1, xe, ye, xp, yp;

    assign o_pop = (r_state == S_IDLE) && !i_q_empty;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_addr    = r_addr;
        n_dirty   = r_dirty;
        n_left    = r_left;
        n_top     = r_top;
        n_dw      = r_dw;
        n_dh      = r_dh;
        n_valid   = 1'b0;
        n_read    = 4'd0;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_cmd.data;

        mask = pfdr_pkg::BIT_MSB >> r_cmd.bitsel;
        x0   = (r_left < r_cmd.x) ? r_left : r_cmd.x;
        y0   = (r_top < r_cmd.y) ? r_top : r_cmd.y;
        xe   = {1'b0, r_left} + r_dw;
        ye   = {1'b0, r_top} + r_dh;
        xp   = {1'b0, r_cmd.x} + 9'd1;
        yp   = {1'b0, r_cmd.y} + 9'd1;
        x1   = (xp > xe) ? xp : xe;
        y1   = (yp > ye) ? yp : ye;

        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_cmd = i_cmd;
                    unique case (i_cmd.op)
                        pfdr_pkg::OP_SET, pfdr_pkg::OP_GET: n_state = S_RMW;
                        pfdr_pkg::OP_CLEAR: begin
                            n_addr  = '0;
                            n_state = S_CLR;
                        end
                        pfdr_pkg::OP_RSTD: begin
                            n_dirty = 1'b0;
                            n_left  = '0;
                            n_top   = '0;
                            n_dw    = '0;
                            n_dh    = '0;
                            n_valid = 1'b1;
                        end
                        default: n_valid = 1'b1;
                    endcase
                end
            end
            S_RMW: begin
                mem_waddr = r_cmd.addr;
                if (i_frame.gray) begin
                    n_read = r_cmd.bitsel[0] ? r_rdata[3:0] : r_rdata[7:4];
                    mem_wdata = r_cmd.bitsel[0] ? {r_rdata[7:4], r_cmd.data[3:0]}
                                                : {r_cmd.data[3:0], r_rdata[3:0]};
                end else begin
                    n_read = {3'd0, (r_rdata & mask) != 8'd0};
                    mem_wdata = r_cmd.data[0] ? (r_rdata | mask) : (r_rdata & ~mask);
                end
                if (r_cmd.op == pfdr_pkg::OP_SET) begin
                    n_read = 4'd0;
                    mem_we = 1'b1;
                    n_dirty = 1'b1;
                    if (!r_dirty) begin
                        n_left = r_cmd.x;
                        n_top  = r_cmd.y;
                        n_dw   = 9'd1;
                        n_dh   = 9'd1;
                    end else begin
                        n_left = x0;
                        n_top  = y0;
                        n_dw   = x1 - {1'b0, x0};
                        n_dh   = y1 - {1'b0, y0};
                    end
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_CLR: begin
                mem_we = 1'b1;
                if (r_addr == i_frame.last) begin
                    n_dirty = 1'b1;
                    n_left  = '0;
                    n_top   = '0;
                    n_dw    = i_frame.w;
                    n_dh    = i_frame.h;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_INIT: begin
                // zero the whole store once after reset
                mem_we    = 1'b1;
                mem_wdata = 8'd0;
                if (r_addr == pfdr_pkg::t_addr'(pfdr_pkg::MEM_BYTES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
        endcase

        if (i_cfg_clr) begin
            n_dirty = 1'b0;
            n_left  = '0;
            n_top   = '0;
            n_dw    = '0;
            n_dh    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_addr  <= '0;
            r_dirty <= 1'b0;
            r_left  <= '0;
            r_top   <= '0;
            r_dw    <= '0;
            r_dh    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_dirty <= n_dirty;
            r_left  <= n_left;
            r_top   <= n_top;
            r_dw    <= n_dw;
            r_dh    <= n_dh;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_read <= n_read;
    end

    // pixel store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (o_pop) begin
            r_rdata <= mem[i_cmd.addr];
        end
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_read;
    assign o_is_dirty   = r_dirty;
    assign o_region_x   = r_left;
    assign o_region_y   = r_top;
    assign o_region_w   = r_dw;
    assign o_region_h   = r_dh;

endmodule

FILE: rtl/packed_framebuffer_dirty_rect.sv
`timescale 1ns / 1ps
// packed_framebuffer_dirty_rect: packed-pixel framebuffer with dirty rectangle, top level
// depends on pfdr_pkg, pfdr_front, pfdr_fifo, pfdr_back
// an item is registered at accept, then queued; the back end takes one only when idle;
// a set reads then writes one store byte, a get reads one, a clear writes one byte a
// cycle over stride*height bytes, and other items write none; the receiver cannot stall
// sync active-low reset clears control and dirty state, then zeroes the whole store
module packed_framebuffer_dirty_rect (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [7:0]         i_pixel_value,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [8:0]         i_cfg_data,
    output logic               o_valid,
    output logic [3:0]         o_read_value,
    output logic               o_is_dirty,
    output logic [7:0]         o_region_x,
    output logic [7:0]         o_region_y,
    output logic [8:0]         o_region_w,
    output logic [8:0]         o_region_h
);

    pfdr_pkg::t_cmd   push_cmd;
    pfdr_pkg::t_cmd   head_cmd;
    pfdr_pkg::t_frame frame;
    logic push, pop, q_full, q_empty, cfg_clr;

    assign cfg_clr = i_cfg_we && (i_cfg_idx == pfdr_pkg::CFG_WIDTH
                                  || i_cfg_idx == pfdr_pkg::CFG_HEIGHT
                                  || i_cfg_idx == pfdr_pkg::CFG_FORMAT);

    pfdr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pixel_value (i_pixel_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .o_frame       (frame)
    );

    pfdr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    pfdr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_clr    (cfg_clr),
        .i_q_empty    (q_empty),
        .i_cmd        (head_cmd),
        .i_frame      (frame),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_read_value (o_read_value),
        .o_is_dirty   (o_is_dirty),
        .o_region_x   (o_region_x),
        .o_region_y   (o_region_y),
        .o_region_w   (o_region_w),
        .o_region_h   (o_region_h)
    );

endmodule

FILE: rtl/pfdr_checker.sv
`timescale 1ns / 1ps
// pfdr_checker: port-level checks of the framebuffer block, bound to the top level
// depends on pfdr_pkg and packed_framebuffer_dirty_rect
module pfdr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic [1:0] i_cfg_idx,
    input logic       o_valid,
    input logic       o_is_dirty,
    input logic [7:0] o_region_x,
    input logic [7:0] o_region_y,
    input logic [8:0] o_region_w,
    input logic [8:0] o_region_h
);

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    // clean state means an empty rectangle at the origin
    a_clean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_is_dirty |-> (o_region_x == 8'd0 && o_region_y == 8'd0
                         && o_region_w == 9'd0 && o_region_h == 9'd0))
        else $error("rectangle not zero while clean");

    // dirty rectangle is never empty
    a_dirty_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_is_dirty |-> (o_region_w != 9'd0 && o_region_h != 9'd0))
        else $error("empty dirty rectangle");

    // rectangle stays inside the largest frame
    a_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((10'(o_region_x) + 10'(o_region_w)) <= 10'(pfdr_pkg::MAX_DIM)
                  && (10'(o_region_y) + 10'(o_region_h)) <= 10'(pfdr_pkg::MAX_DIM)))
        else $error("dirty rectangle out of range");

    // a register write clears the dirty state
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx == pfdr_pkg::CFG_WIDTH || i_cfg_idx == pfdr_pkg::CFG_HEIGHT
                      || i_cfg_idx == pfdr_pkg::CFG_FORMAT)) |=> !o_is_dirty)
        else $error("dirty state kept across a register write");

endmodule

bind packed_framebuffer_dirty_rect pfdr_checker u_pfdr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_cfg_we   (i_cfg_we),
    .i_cfg_idx  (i_cfg_idx),
    .o_valid    (o_valid),
    .o_is_dirty (o_is_dirty),
    .o_region_x (o_region_x),
    .o_region_y (o_region_y),
    .o_region_w (o_region_w),
    .o_region_h (o_region_h)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for packed_framebuffer_dirty_rect, with a command driver,
// a result monitor and a predictor of the packed store and the dirty rectangle
// depends on pfdr_pkg and packed_framebuffer_dirty_rect
module testbench;
    import pfdr_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         req;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [7:0]         value;
    } t_fb_req;

    typedef struct packed {
        logic [3:0] read_value;
        logic       is_dirty;
        logic [7:0] region_x;
        logic [7:0] region_y;
        logic [8:0] region_w;
        logic [8:0] region_h;
    } t_fb_resp;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [8:0] i_cfg_data = '0;
    logic       o_valid;
    logic [3:0] o_read_value;
    logic       o_is_dirty;
    logic [7:0] o_region_x;
    logic [7:0] o_region_y;
    logic [8:0] o_region_w;
    logic [8:0] o_region_h;

    t_fb_req  cur_item = '{REQ_RSTD, 16'sd0, 16'sd0, 8'd0};
    t_fb_req  draw_queue[$];
    t_fb_resp status_due[$];
    bit       taken = 1'b0;
    int       idle_pct = 38;
    int       mismatches = 0;
    int       random_items = 0;

    // predictor state
    logic [8:0] fb_width = '0;
    logic [8:0] fb_height = '0;
    bit         fb_gray = 1'b0;
    logic [7:0] frame_mem [MEM_BYTES] = '{default: 8'h00};
    bit         byte_written [MEM_BYTES];
    bit         dirty_on = 1'b0;
    int         rect_x = 0;
    int         rect_y = 0;
    int         rect_w = 0;
    int         rect_h = 0;

    packed_framebuffer_dirty_rect dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (cur_item.req),
        .i_pos_x       (cur_item.x),
        .i_pos_y       (cur_item.y),
        .i_pixel_value (cur_item.value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_is_dirty    (o_is_dirty),
        .o_region_x    (o_region_x),
        .o_region_y    (o_region_y),
        .o_region_w    (o_region_w),
        .o_region_h    (o_region_h)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_region();
        dirty_on = 1'b0;
        rect_x = 0;
        rect_y = 0;
        rect_w = 0;
        rect_h = 0;
    endfunction

    function automatic int row_stride();
        return fb_gray ? (int'(fb_width) + 1) / 2 : (int'(fb_width) + 7) / 8;
    endfunction

    function automatic bit frame_ok();
        if (fb_width == 0 || fb_height == 0) return 1'b0;
        if (fb_width > MAX_DIM || fb_height > MAX_DIM) return 1'b0;
        return row_stride() * int'(fb_height) <= MEM_BYTES;
    endfunction

    // byte holding the pixel, -1 when the access clips
    function automatic int pixel_addr(logic signed [15:0] x, logic signed [15:0] y);
        int sx;
        int sy;
        sx = x;
        sy = y;
        if (!frame_ok() || sx < 0 || sy < 0) return -1;
        if (sx >= int'(fb_width) || sy >= int'(fb_height)) return -1;
        return sy * row_stride() + (fb_gray ? sx / 2 : sx / 8);
    endfunction

    function automatic void grow_region(int x, int y);
        int x1;
        int y1;
        if (!dirty_on) begin
            dirty_on = 1'b1;
            rect_x = x;
            rect_y = y;
            rect_w = 1;
            rect_h = 1;
            return;
        end
        x1 = rect_x + rect_w;
        y1 = rect_y + rect_h;
        if (x + 1 > x1) x1 = x + 1;
        if (y + 1 > y1) y1 = y + 1;
        if (x < rect_x) rect_x = x;
        if (y < rect_y) rect_y = y;
        rect_w = x1 - rect_x;
        rect_h = y1 - rect_y;
    endfunction

    function automatic t_fb_resp perform_request(t_fb_req rq);
        t_fb_resp   rs;
        int         addr;
        int         px;
        int         py;
        int         i;
        logic [7:0] b;
        logic [7:0] mask;
        logic [7:0] fill;
        rs = '0;
        addr = pixel_addr(rq.x, rq.y);
        px = rq.x;
        py = rq.y;
        if (rq.req == REQ_SET || rq.req == REQ_GET) begin
            if (addr >= 0) begin
                b = frame_mem[addr];
                if (fb_gray) begin
                    if (rq.req == REQ_SET)
                        frame_mem[addr] = px[0] ? {b[7:4], rq.value[3:0]}
                                                : {rq.value[3:0], b[3:0]};
                    else
                        rs.read_value = px[0] ? b[3:0] : b[7:4];
                end else begin
                    mask = BIT_MSB >> px[2:0];
                    if (rq.req == REQ_SET)
                        frame_mem[addr] = (rq.value != 0) ? (b | mask) : (b & ~mask);
                    else
                        rs.read_value = ((b & mask) != 0) ? 4'd1 : 4'd0;
                end
                if (rq.req == REQ_SET) grow_region(px, py);
            end
        end else if (rq.req == REQ_CLEAR) begin
            if (frame_ok()) begin
                fill = fb_gray ? {2{rq.value[3:0]}} : ((rq.value != 0) ? BYTE_ALL : 8'h00);
                for (i = 0; i < row_stride() * int'(fb_height); i++) frame_mem[i] = fill;
                dirty_on = 1'b1;
                rect_x = 0;
                rect_y = 0;
                rect_w = fb_width;
                rect_h = fb_height;
            end
        end else begin
            clear_region();
        end
        rs.is_dirty = dirty_on;
        rs.region_x = 8'(rect_x);
        rs.region_y = 8'(rect_y);
        rs.region_w = 9'(rect_w);
        rs.region_h = 9'(rect_h);
        return rs;
    endfunction

    // queue an item; a get of a never-written byte becomes a set of it
    function automatic void enqueue(logic [1:0] req, logic signed [15:0] x,
                                    logic signed [15:0] y, logic [7:0] v);
        t_fb_req it;
        int      addr;
        int      i;
        addr = pixel_addr(x, y);
        if (req == REQ_GET && addr >= 0 && !byte_written[addr]) req = REQ_SET;
        if (req == REQ_SET && addr >= 0) byte_written[addr] = 1'b1;
        if (req == REQ_CLEAR && frame_ok())
            for (i = 0; i < row_stride() * int'(fb_height); i++) byte_written[i] = 1'b1;
        it.req = req;
        it.x = x;
        it.y = y;
        it.value = v;
        draw_queue.push_back(it);
    endfunction

    function automatic logic signed [15:0] pick_coord(int lim);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return -16'sd1;
        if (r == 1) return 16'(lim);
        if (r == 2) return 16'($urandom());
        return (lim > 0) ? 16'($urandom_range(0, lim - 1)) : 16'd0;
    endfunction

    function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic drain();
        while (draw_queue.size() != 0 || start || busy || status_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH: fb_width = data;
            CFG_HEIGHT: fb_height = data;
            CFG_FORMAT: fb_gray = data[0];
            default: return;
        endcase
        clear_region();
    endtask

    task automatic random_phase();
        int         wd;
        int         ht;
        int         k;
        int         i;
        int         n;
        int         r;
        bit         gray;
        bit         big;
        logic [1:0] idx;
        logic [1:0] req;
        logic [7:0] v;
        drain();
        gray = $urandom_range(0, 1);
        k = $urandom_range(0, 19);
        if (k < 13) begin
            wd = $urandom_range(1, 24);
            ht = $urandom_range(1, 12);
        end else if (k < 16) begin
            case ($urandom_range(0, 3))
                0: begin wd = 0; ht = $urandom_range(1, 256); end
                1: begin wd = $urandom_range(1, 256); ht = 0; end
                2: begin wd = $urandom_range(257, 511); ht = $urandom_range(1, 511); end
                default: begin wd = 256; ht = $urandom_range(65, 256); gray = 1'b1; end
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0: begin wd = 256; ht = 256; gray = 1'b0; end
                1: begin wd = 256; ht = 64; gray = 1'b1; end
                default: begin wd = $urandom_range(100, 256); ht = $urandom_range(1, 256); end
            endcase
        end
        if ($urandom_range(0, 3) == 0) begin
            // partial update: the frame and maybe the dirty state carry over
            if ($urandom_range(0, 1) == 0) write_reg(CFG_FORMAT, gray);
            else write_reg(CFG_UNUSED, 9'($urandom_range(0, 511)));
        end else begin
            k = $urandom_range(0, 2);
            for (i = 0; i < 3; i++) begin
                idx = 2'((k + i) % 3);
                case (idx)
                    CFG_WIDTH: write_reg(CFG_WIDTH, 9'(wd));
                    CFG_HEIGHT: write_reg(CFG_HEIGHT, 9'(ht));
                    default: write_reg(CFG_FORMAT, gray);
                endcase
            end
        end
        big = frame_ok() && row_stride() * int'(fb_height) > 512;
        n = $urandom_range(20, 60);
        if (frame_ok() && (big || $urandom_range(0, 1) == 0))
            enqueue(REQ_CLEAR, 0, 0, 8'($urandom_range(0, 255)));
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            v = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            if (r < 45) begin
                enqueue(REQ_SET, pick_coord(fb_width), pick_coord(fb_height), v);
            end else if (r < 80) begin
                enqueue(REQ_GET, pick_coord(fb_width), pick_coord(fb_height), v);
            end else if (r < 83 && !big) begin
                enqueue(REQ_CLEAR, pick_coord(fb_width), pick_coord(fb_height), v);
            end else if (r < 90) begin
                enqueue(REQ_RSTD, pick_coord(fb_width), pick_coord(fb_height), v);
            end else begin
                req = 2'($urandom_range(0, 3));
                if (req == REQ_CLEAR && big) req = REQ_GET;
                enqueue(req, 16'($urandom()), 16'($urandom()), v);
            end
        end
        random_items += n;
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || taken) begin
            if (draw_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                cur_item <= draw_queue.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_fb_resp want;
        if (i_rst_n && o_valid) begin
            if (status_due.size() == 0) begin
                $error("result strobe with no item outstanding");
                mismatches++;
            end else begin
                want = status_due.pop_front();
                check_field("read_value", want.read_value, o_read_value);
                check_field("is_dirty", want.is_dirty, o_is_dirty);
                check_field("region_x", want.region_x, o_region_x);
                check_field("region_y", want.region_y, o_region_y);
                check_field("region_w", want.region_w, o_region_w);
                check_field("region_h", want.region_h, o_region_h);
            end
        end
        taken = i_rst_n && start && !busy;
        if (taken) status_due.push_back(perform_request(cur_item));
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero-sized frame out of reset
        enqueue(REQ_SET, 0, 0, BYTE_ALL);
        enqueue(REQ_GET, 0, 0, 8'h00);
        enqueue(REQ_CLEAR, 0, 0, BYTE_ALL);
        enqueue(REQ_RSTD, 0, 0, 8'h00);
        drain();

        // largest mono frame, fills the whole store
        write_reg(CFG_WIDTH, 9'd256);
        write_reg(CFG_HEIGHT, 9'd256);
        write_reg(CFG_FORMAT, 9'd0);
        enqueue(REQ_CLEAR, 0, 0, 8'h01);
        enqueue(REQ_GET, 255, 255, 8'h00);
        enqueue(REQ_SET, 255, 255, 8'h00);
        enqueue(REQ_GET, 255, 255, 8'h00);
        enqueue(REQ_SET, -32768, 32767, BYTE_ALL);
        enqueue(REQ_SET, 256, 0, BYTE_ALL);
        enqueue(REQ_RSTD, 0, 0, 8'h00);
        enqueue(REQ_SET, 7, 3, BIT_MSB);
        enqueue(REQ_SET, 200, 100, 8'h01);
        enqueue(REQ_GET, 7, 3, 8'h00);
        drain();

        // small gray frame with odd width
        write_reg(CFG_FORMAT, 9'd1);
        write_reg(CFG_WIDTH, 9'd3);
        write_reg(CFG_HEIGHT, 9'd2);
        enqueue(REQ_CLEAR, 0, 0, 8'hA5);
        enqueue(REQ_SET, 0, 0, BYTE_ALL);
        enqueue(REQ_SET, 1, 0, 8'hF0);
        enqueue(REQ_GET, 0, 0, 8'h00);
        enqueue(REQ_GET, 1, 0, 8'h00);
        enqueue(REQ_GET, 2, 1, 8'h00);
        enqueue(REQ_SET, 2, 1, 8'h0C);
        enqueue(REQ_GET, 2, 1, 8'h00);
        drain();

        // gray frame one row beyond the store
        write_reg(CFG_WIDTH, 9'd256);
        write_reg(CFG_HEIGHT, 9'd65);
        enqueue(REQ_CLEAR, 0, 0, 8'h03);
        enqueue(REQ_GET, 0, 0, 8'h00);

        while (random_items < 700) begin
            if (random_items < 233) idle_pct = 38;
            else if (random_items < 466) idle_pct = 87;
            else idle_pct = 0;
            random_phase();
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && status_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pfdr_pkg.sv
rtl/pfdr_front.sv
rtl/pfdr_fifo.sv
rtl/pfdr_back.sv
rtl/packed_framebuffer_dirty_rect.sv
rtl/pfdr_checker.sv
tb/sv/testbench.sv
